>>> design/swlm_pkg.sv
// Shared types and constants for the stopwatch with lap memory.
`default_nettype none
package swlm_pkg;

  // Command codes carried in the request
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_LAP    = 3'd5,
    CMD_READ   = 3'd6
  } cmd_t;

  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int CentiW  = 7;
  localparam int IndexW  = 4;
  localparam int CountW  = 4;

  localparam int CentisPerSecond  = 100;
  localparam int SecondsPerMinute = 60;
  localparam int MinutesPerHour   = 60;
  localparam int HoursPerDay      = 24;

  // One stored lap, hours in the top bits
  typedef struct packed {
    logic [HourW-1:0]   hours;
    logic [MinuteW-1:0] minutes;
    logic [SecondW-1:0] seconds;
    logic [CentiW-1:0]  centis;
  } lap_entry_t;

  // Control handed to each counter cell
  typedef struct packed {
    logic clear;
    logic inc;
  } digit_ctrl_t;

  // Control broadcast to every lap cell
  typedef struct packed {
    logic              capture;
    logic              read;
    logic [IndexW-1:0] index;
  } lap_ctrl_t;

endpackage
`default_nettype wire

>>> design/swlm_digit_cell.sv
// Modulo counter cell of the time cascade, passing its carry to the next cell.
`default_nettype none
module swlm_digit_cell #(
  parameter int MOD = 10,
  parameter int W   = (MOD > 1) ? $clog2(MOD) : 1
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire swlm_pkg::digit_ctrl_t ctrl,
  output logic [W-1:0]               count,
  output logic [W-1:0]               count_next,
  output logic                       carry
);
  import swlm_pkg::*;

  localparam logic [W-1:0] Top = W'(MOD - 1);

  // Wrap at the modulus and hand the carry on
  assign carry = ctrl.inc && (count == Top);

  always_comb begin
    if (ctrl.clear) begin
      count_next = '0;
    end else if (carry) begin
      count_next = '0;
    end else if (ctrl.inc) begin
      count_next = count + W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

>>> design/swlm_lap_cell.sv
// One lap store slot: shifts in its left neighbor on capture, answers a read of its index.
`default_nettype none
module swlm_lap_cell #(
  parameter int IDX = 0
) (
  input  wire                       clk,
  input  wire swlm_pkg::lap_ctrl_t  ctrl,
  input  wire                       occupied,
  input  wire swlm_pkg::lap_entry_t entry_in,
  output swlm_pkg::lap_entry_t      entry,
  output swlm_pkg::lap_entry_t      read_data
);
  import swlm_pkg::*;

  logic match;

  // Shift toward the older end on capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      entry <= entry_in;
    end
  end

  // Drive the read bus only when this slot is addressed and filled
  assign match     = ctrl.read && occupied && (int'(ctrl.index) == IDX);
  assign read_data = match ? entry : '0;

endmodule
`default_nettype wire

>>> design/stopwatch_with_lap_memory_top.sv
// Top level of the stopwatch with lap memory: counter cells, lap cells, result register.
//
// Usage:
//   Requests arrive on the s_ channel, one per millisecond tick or command;
//   s_tdata holds cmd (0 tick, 1 start, 2 pause, 3 resume, 4 stop,
//   5 lap capture, 6 lap read) and lap_index. Every request yields exactly
//   one result on the m_ channel: the elapsed count after the request, the
//   run flag, the number of stored laps and, for a lap read, the entry.
//   An accepted request's result is registered and shows from the cycle
//   after acceptance on. Throughput is 1 request per cycle while the
//   receiver takes results, set by the carry ripple through the five counter
//   cells and the one-step shift of the lap cells, both in the cycle of acceptance.
//   When the receiver stalls, the result is held in the output register and
//   s_tready falls until it is taken; s_tready is high whenever the register
//   is empty or being emptied in the same cycle.
//   Reset (rst, synchronous) clears the count, halts the watch, empties the
//   lap store and drops any pending result. Lap slots carry no reset; only
//   filled slots are ever read.
`default_nettype none
module stopwatch_with_lap_memory_top #(
  parameter int LAP_DEPTH       = 12,
  parameter int TICKS_PER_CENTI = 10
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // cmd[2:0], lap_index[6:3], zero[7]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [55:0] m_tdata    // hours[4:0], minutes[10:5], seconds[16:11],
                                 // centis[23:17], running[24], lap_count[28:25],
                                 // lap_valid[29], lap_hours[34:30],
                                 // lap_minutes[40:35], lap_seconds[46:41],
                                 // lap_centis[53:47], zero[55:54]
);
  import swlm_pkg::*;

  localparam int FillW = $clog2(LAP_DEPTH + 1);
  localparam int SubW  = (TICKS_PER_CENTI > 1) ? $clog2(TICKS_PER_CENTI) : 1;

  logic              accept;
  cmd_t              cmd;
  logic [IndexW-1:0] lap_index;

  logic do_tick;
  logic do_clear;

  digit_ctrl_t sub_ctrl, centi_ctrl, second_ctrl, minute_ctrl, hour_ctrl;

  logic               sub_carry;
  logic [CentiW-1:0]  centi_count, centi_next;
  logic               centi_carry;
  logic [SecondW-1:0] second_count, second_next;
  logic               second_carry;
  logic [MinuteW-1:0] minute_count, minute_next;
  logic               minute_carry;
  logic [HourW-1:0]   hour_count, hour_next;

  logic             run_flag, run_flag_next;
  logic [FillW-1:0] lap_fill, lap_fill_next;

  lap_ctrl_t  lap_ctrl;
  lap_entry_t now_entry;
  lap_entry_t chain  [LAP_DEPTH+1];
  lap_entry_t rd_bus [LAP_DEPTH];
  lap_entry_t rd_data;
  logic       rd_valid;

  // Handshake and decode
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cmd       = cmd_t'(s_tdata[2:0]);
  assign lap_index = s_tdata[6:3];

  always_comb begin
    do_tick       = 1'b0;
    do_clear      = 1'b0;
    run_flag_next = run_flag;
    lap_ctrl      = '0;
    lap_ctrl.index = lap_index;
    lap_fill_next = lap_fill;
    if (accept) begin
      case (cmd)
        CMD_TICK:   do_tick = run_flag;
        CMD_START: begin
          do_clear      = 1'b1;
          run_flag_next = 1'b1;
        end
        CMD_PAUSE:  run_flag_next = 1'b0;
        CMD_RESUME: run_flag_next = 1'b1;
        CMD_STOP: begin
          do_clear      = 1'b1;
          run_flag_next = 1'b0;
          lap_fill_next = '0;
        end
        CMD_LAP: begin
          lap_ctrl.capture = 1'b1;
          if (lap_fill < FillW'(LAP_DEPTH)) begin
            lap_fill_next = lap_fill + FillW'(1);
          end
        end
        CMD_READ:   lap_ctrl.read = 1'b1;
        default:    ;
      endcase
    end
  end

  // Counter cascade, each cell's carry feeds the next
  assign sub_ctrl    = '{clear: do_clear, inc: do_tick};
  assign centi_ctrl  = '{clear: do_clear, inc: sub_carry};
  assign second_ctrl = '{clear: do_clear, inc: centi_carry};
  assign minute_ctrl = '{clear: do_clear, inc: second_carry};
  assign hour_ctrl   = '{clear: do_clear, inc: minute_carry};

  swlm_digit_cell #(.MOD(TICKS_PER_CENTI), .W(SubW)) u_sub (
    .clk(clk), .rst(rst), .ctrl(sub_ctrl),
    .count(), .count_next(), .carry(sub_carry)
  );

  swlm_digit_cell #(.MOD(CentisPerSecond), .W(CentiW)) u_centi (
    .clk(clk), .rst(rst), .ctrl(centi_ctrl),
    .count(centi_count), .count_next(centi_next), .carry(centi_carry)
  );

  swlm_digit_cell #(.MOD(SecondsPerMinute), .W(SecondW)) u_second (
    .clk(clk), .rst(rst), .ctrl(second_ctrl),
    .count(second_count), .count_next(second_next), .carry(second_carry)
  );

  swlm_digit_cell #(.MOD(MinutesPerHour), .W(MinuteW)) u_minute (
    .clk(clk), .rst(rst), .ctrl(minute_ctrl),
    .count(minute_count), .count_next(minute_next), .carry(minute_carry)
  );

  swlm_digit_cell #(.MOD(HoursPerDay), .W(HourW)) u_hour (
    .clk(clk), .rst(rst), .ctrl(hour_ctrl),
    .count(hour_count), .count_next(hour_next), .carry()
  );

  // Run flag and lap fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag <= 1'b0;
      lap_fill <= '0;
    end else begin
      run_flag <= run_flag_next;
      lap_fill <= lap_fill_next;
    end
  end

  // Lap cells: the current count enters at slot 0, the oldest falls off the end
  assign now_entry = '{hours: hour_count, minutes: minute_count,
                       seconds: second_count, centis: centi_count};
  assign chain[0]  = now_entry;

  for (genvar i = 0; i < LAP_DEPTH; i++) begin : g_lap
    swlm_lap_cell #(.IDX(i)) u_cell (
      .clk(clk),
      .ctrl(lap_ctrl),
      .occupied(lap_fill > FillW'(i)),
      .entry_in(chain[i]),
      .entry(chain[i+1]),
      .read_data(rd_bus[i])
    );
  end

  // Combine the read bus; at most one cell drives it
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < LAP_DEPTH; i++) begin
      rd_data = rd_data | rd_bus[i];
    end
  end

  assign rd_valid = lap_ctrl.read && (FillW'(lap_index) < lap_fill) &&
                    (int'(lap_index) < LAP_DEPTH);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, rd_data.centis, rd_data.seconds, rd_data.minutes,
                  rd_data.hours, rd_valid, CountW'(lap_fill_next),
                  run_flag_next, centi_next, second_next, minute_next, hour_next};
    end
  end

endmodule
`default_nettype wire

>>> design/swlm_checker.sv
// Port-level checks for the stopwatch with lap memory, bound to the top level.
`default_nettype none
module swlm_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [7:0]  s_tdata,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [55:0] m_tdata
);
  import swlm_pkg::*;

  logic req;
  assign req = s_tvalid && s_tready;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Drop any pending result at reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stop clears count, laps and run flag
  a_stop: assert property (@(posedge clk) disable iff (rst)
    req && (s_tdata[2:0] == CMD_STOP) |=>
      m_tvalid && (m_tdata[29:0] == 30'd0))
    else $error("stop did not clear state");

  // Start clears the count and runs
  a_start: assert property (@(posedge clk) disable iff (rst)
    req && (s_tdata[2:0] == CMD_START) |=>
      m_tvalid && (m_tdata[23:0] == 24'd0) && m_tdata[24])
    else $error("start did not clear and run");

  // Only a lap read returns lap data
  a_read: assert property (@(posedge clk) disable iff (rst)
    req && (s_tdata[2:0] != CMD_READ) |=>
      !m_tdata[29] && (m_tdata[53:30] == 24'd0))
    else $error("lap data without a read");

endmodule

bind stopwatch_with_lap_memory_top swlm_checker u_swlm_checker (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

>>> tb/stopwatch_with_lap_memory_top_test.sv
// Self-checking testbench for the stopwatch with lap memory, with random stream pacing.
`timescale 1ns / 1ps
module stopwatch_with_lap_memory_top_test;
  import swlm_pkg::*;

  localparam int          MsPerCenti = 10;
  localparam int          LapSlots   = 12;
  localparam logic [2:0]  CMD_UNUSED = 3'd7;
  localparam int          CycleLimit = 20_000_000;
  localparam int          RandomReqs = 480;
  localparam int          SoakTicks  = 400;

  // One request waiting to be offered
  typedef struct {
    logic [2:0]        code;
    logic [IndexW-1:0] index;
    bit                drain_first;
  } request_t;

  // One result as seen on the master side
  typedef struct {
    logic [HourW-1:0]   hours;
    logic [MinuteW-1:0] minutes;
    logic [SecondW-1:0] seconds;
    logic [CentiW-1:0]  centis;
    logic               running;
    logic [CountW-1:0]  laps_held;
    logic               lap_ok;
    lap_entry_t         lap;
  } watch_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  request_t    pending_requests[$];
  watch_view_t expected_views[$];

  int requests_sent = 0;
  int results_seen  = 0;
  int fail_count    = 0;
  int send_idle     = 0;
  int recv_idle     = 0;
  int hold_left     = 0;
  int next_hold_at  = 40;
  int cycles        = 0;

  // Predicted stopwatch state
  int                 ms_in_centi;
  logic [CentiW-1:0]  centi_now;
  logic [SecondW-1:0] second_now;
  logic [MinuteW-1:0] minute_now;
  logic [HourW-1:0]   hour_now;
  logic               counting;
  lap_entry_t         lap_mem[LapSlots];
  int                 laps_stored;

  stopwatch_with_lap_memory_top #(
    .LAP_DEPTH(LapSlots),
    .TICKS_PER_CENTI(MsPerCenti)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_idle(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic watch_view_t unpack_view(input logic [55:0] d);
    watch_view_t v;
    v.hours         = d[4:0];
    v.minutes       = d[10:5];
    v.seconds       = d[16:11];
    v.centis        = d[23:17];
    v.running       = d[24];
    v.laps_held     = d[28:25];
    v.lap_ok        = d[29];
    v.lap.hours     = d[34:30];
    v.lap.minutes   = d[40:35];
    v.lap.seconds   = d[46:41];
    v.lap.centis    = d[53:47];
    return v;
  endfunction

  task automatic clear_elapsed();
    ms_in_centi = 0;
    centi_now   = '0;
    second_now  = '0;
    minute_now  = '0;
    hour_now    = '0;
  endtask

  // Ripple one millisecond through the cascade
  task automatic tick_elapsed();
    ms_in_centi++;
    if (ms_in_centi < MsPerCenti) return;
    ms_in_centi = 0;
    if (centi_now < CentisPerSecond - 1) begin
      centi_now++;
      return;
    end
    centi_now = '0;
    if (second_now < SecondsPerMinute - 1) begin
      second_now++;
      return;
    end
    second_now = '0;
    if (minute_now < MinutesPerHour - 1) begin
      minute_now++;
      return;
    end
    minute_now = '0;
    if (hour_now < HoursPerDay - 1) hour_now++;
    else hour_now = '0;
  endtask

  // Advance the predicted stopwatch by one request and queue the result it yields
  task automatic apply_request(input logic [2:0] code, input logic [IndexW-1:0] index);
    watch_view_t v;
    v.lap    = '0;
    v.lap_ok = 1'b0;
    case (code)
      CMD_TICK: begin
        if (counting) tick_elapsed();
      end
      CMD_START: begin
        clear_elapsed();
        counting = 1'b1;
      end
      CMD_PAUSE:  counting = 1'b0;
      CMD_RESUME: counting = 1'b1;
      CMD_STOP: begin
        clear_elapsed();
        counting    = 1'b0;
        laps_stored = 0;
      end
      CMD_LAP: begin
        for (int i = LapSlots - 1; i > 0; i--) lap_mem[i] = lap_mem[i-1];
        lap_mem[0].hours   = hour_now;
        lap_mem[0].minutes = minute_now;
        lap_mem[0].seconds = second_now;
        lap_mem[0].centis  = centi_now;
        if (laps_stored < LapSlots) laps_stored++;
      end
      CMD_READ: begin
        if (int'(index) < laps_stored) begin
          v.lap_ok = 1'b1;
          v.lap    = lap_mem[index];
        end
      end
      default: ;
    endcase
    v.hours     = hour_now;
    v.minutes   = minute_now;
    v.seconds   = second_now;
    v.centis    = centi_now;
    v.running   = counting;
    v.laps_held = laps_stored[CountW-1:0];
    expected_views.push_back(v);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_request(input logic [2:0] code, input int index, input bit drain = 1'b0);
    request_t r;
    r.code        = code;
    r.index       = index[IndexW-1:0];
    r.drain_first = drain;
    pending_requests.push_back(r);
  endtask

  // Offer queued requests with random gaps; predict each one as it is taken
  always @(posedge clk) begin : feed
    bit       offer;
    request_t head;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_idle = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        head = pending_requests.pop_front();
        apply_request(head.code, head.index);
        requests_sent <= requests_sent + 1;
        send_idle = pick_idle(((requests_sent / 150) % 4) == 0);
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_idle > 0) send_idle--;
        else if (pending_requests.size() > 0 &&
                 (!pending_requests[0].drain_first || expected_views.size() == 0))
          offer = 1'b1;
      end
      s_tvalid <= offer;
      if (offer) s_tdata <= {1'b0, pending_requests[0].index, pending_requests[0].code};
    end
  end

  // Hold the receiver off for a long stretch every few hundred requests
  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      next_hold_at <= 40;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (requests_sent >= next_hold_at) begin
      hold_left    <= 60;
      next_hold_at <= next_hold_at + 400;
    end
  end

  // Take results with random stalls and check each against the oldest prediction
  always @(posedge clk) begin : take
    watch_view_t got;
    watch_view_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_idle = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = unpack_view(m_tdata);
        if (expected_views.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          compare_field("hours", want.hours, got.hours);
          compare_field("minutes", want.minutes, got.minutes);
          compare_field("seconds", want.seconds, got.seconds);
          compare_field("centis", want.centis, got.centis);
          compare_field("running", want.running, got.running);
          compare_field("lap_count", want.laps_held, got.laps_held);
          compare_field("lap_valid", want.lap_ok, got.lap_ok);
          compare_field("lap_hours", want.lap.hours, got.lap.hours);
          compare_field("lap_minutes", want.lap.minutes, got.lap.minutes);
          compare_field("lap_seconds", want.lap.seconds, got.lap.seconds);
          compare_field("lap_centis", want.lap.centis, got.lap.centis);
        end
        results_seen <= results_seen + 1;
        recv_idle = pick_idle(((results_seen / 150) % 4) == 1);
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int issued;
    clear_elapsed();
    counting    = 1'b0;
    laps_stored = 0;

    // Directed: idle-state commands, unused code, centisecond carry, out-of-range reads
    queue_request(CMD_READ, 0);
    queue_request(CMD_TICK, 0);
    queue_request(CMD_PAUSE, 0);
    queue_request(CMD_UNUSED, 15);
    queue_request(CMD_START, 0);
    for (int i = 0; i < 11; i++) queue_request(CMD_TICK, 0);
    queue_request(CMD_RESUME, 0);
    queue_request(CMD_LAP, 0);
    queue_request(CMD_PAUSE, 0);
    queue_request(CMD_TICK, 0);
    queue_request(CMD_READ, 0);
    queue_request(CMD_READ, 15);
    queue_request(CMD_READ, 1);
    queue_request(CMD_STOP, 0);
    queue_request(CMD_READ, 0, 1'b1);

    // Random: mostly a running watch with laps and reads, some noise
    queue_request(CMD_START, 0, 1'b1);
    issued = 0;
    while (issued < RandomReqs) begin
      r = $urandom_range(0, 999);
      if (r < 580)      queue_request(CMD_TICK, $urandom_range(0, 15));
      else if (r < 680) queue_request(CMD_LAP, $urandom_range(0, 15));
      else if (r < 820) queue_request(CMD_READ, ($urandom_range(0, 9) < 8) ?
                                      $urandom_range(0, LapSlots - 1) :
                                      $urandom_range(LapSlots, 15));
      else if (r < 860) queue_request(CMD_PAUSE, 0);
      else if (r < 920) queue_request(CMD_RESUME, 0);
      else if (r < 950) queue_request(CMD_START, 0);
      else if (r < 960) queue_request(CMD_STOP, 0);
      else if (r < 980) queue_request(CMD_UNUSED, $urandom_range(0, 15));
      else              queue_request(CMD_TICK, 0, $urandom_range(0, 9) == 0);
      issued++;
    end

    // Long run: many centisecond carries, overfill the lap store
    queue_request(CMD_START, 0, 1'b1);
    for (int i = 1; i <= SoakTicks; i++) begin
      queue_request(CMD_TICK, 0);
      if (i % 30 == 0) begin
        queue_request(CMD_LAP, 0);
        queue_request(CMD_READ, $urandom_range(0, 15));
      end
      if (i == SoakTicks / 2) begin
        queue_request(CMD_PAUSE, 0);
        queue_request(CMD_TICK, 0);
        queue_request(CMD_RESUME, 0);
      end
    end
    for (int i = 0; i < 16; i++) queue_request(CMD_READ, i);
    queue_request(CMD_STOP, 0);
    queue_request(CMD_READ, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || expected_views.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
